// ===== rtl/core/bounded_deque_with_search_assert.svh =====
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define BDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdq check failed");

// Next-cycle implication, quiet while reset is high.
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdq check failed");

`endif

// ===== rtl/core/bdq_pkg.sv =====
// Constants, codes and types shared by the deque cells and the top level.
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int IDX_W       = $clog2(DEPTH);

   // Command codes
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_CONTAINS   = 3'd4;
   localparam logic [2:0] CMD_REMOVE     = 3'd5;
   localparam logic [2:0] CMD_CLEAR      = 3'd6;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ZERO  = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   // Cell update modes
   localparam logic [2:0] CELL_HOLD       = 3'd0;
   localparam logic [2:0] CELL_TAKE_LEFT  = 3'd1;
   localparam logic [2:0] CELL_TAKE_RIGHT = 3'd2;
   localparam logic [2:0] CELL_LOAD       = 3'd3;
   localparam logic [2:0] CELL_COMPACT    = 3'd4;

   // Control broadcast to every cell
   typedef struct packed {
      logic [2:0]             mode;
      logic [VALUE_WIDTH-1:0] key;
      logic [CNT_W-1:0]       count;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/core/bdq_cell.sv =====
// One deque slot: holds a word, shifts with its neighbors, matches the key.
`timescale 1ns / 1ps
`default_nettype none
module bdq_cell (
   input  wire logic                           clock,
   input  wire bdq_pkg::cell_ctl_type          ctl,
   input  wire logic [bdq_pkg::IDX_W-1:0]      cell_index,
   input  wire logic [bdq_pkg::VALUE_WIDTH-1:0] left_value,
   input  wire logic [bdq_pkg::VALUE_WIDTH-1:0] right_value,
   input  wire logic                           kill_in,
   output logic [bdq_pkg::VALUE_WIDTH-1:0]     value_out,
   output logic [bdq_pkg::VALUE_WIDTH-1:0]     tail_value,
   output logic                                kill_out
);
   import bdq_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;
   logic [CNT_W-1:0]       pos;
   logic                   occupied;
   logic                   is_last;
   logic                   match;

   assign pos      = CNT_W'(cell_index);
   assign occupied = pos < ctl.count;
   assign is_last  = (pos + CNT_W'(1)) == ctl.count;
   assign match    = occupied && (value_ff == ctl.key);

   // Pass the kill on once this or any earlier slot holds the key
   assign kill_out   = kill_in | match;
   assign value_out  = value_ff;
   assign tail_value = is_last ? value_ff : '0;

   // Select the next word from the neighbors
   always_comb begin
      value_in = value_ff;
      case (ctl.mode)
         CELL_TAKE_LEFT:  value_in = left_value;
         CELL_TAKE_RIGHT: value_in = right_value;
         CELL_LOAD: begin
            if (pos == ctl.count) value_in = ctl.key;
         end
         CELL_COMPACT: begin
            if (kill_out) value_in = right_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/bounded_deque_with_search.sv =====
// Bounded deque of nonzero words with membership test and remove-all.
// Sequence: the accepting edge enters the operation state, then the finish state; the result
// strobe is registered from the finish state. Remove stays in the operation state while any
// entry matches, squeezing out one match per cycle. A new word is taken in the strobe cycle,
// so the block cannot take a new word before the last one is through.
// Reset (synchronous): count cleared and control idle; slot contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module bounded_deque_with_search (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [2:0]                     req_command,
   input  wire logic [bdq_pkg::VALUE_WIDTH-1:0] req_item_value,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [bdq_pkg::VALUE_WIDTH-1:0]     rsp_popped_value,
   output logic                                rsp_found,
   output logic [bdq_pkg::VALUE_WIDTH-1:0]     rsp_front_value,
   output logic [bdq_pkg::VALUE_WIDTH-1:0]     rsp_back_value,
   output logic                                rsp_is_empty,
   output logic [bdq_pkg::CNT_W-1:0]           rsp_entry_count
);
   import bdq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_OP   = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [2:0]             cmd_ff;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic [1:0]             status_ff, status_in;
   logic [VALUE_WIDTH-1:0] popped_ff, popped_in;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] front_ff, back_ff;
   logic                   empty_ff;
   logic [CNT_W-1:0]       rsp_count_ff;
   logic                   accept;
   logic [2:0]             mode;
   cell_ctl_type           ctl;

   logic [VALUE_WIDTH-1:0] value_w [DEPTH];
   logic [VALUE_WIDTH-1:0] tail_w  [DEPTH];
   logic [DEPTH:0]         kill_w;
   logic [VALUE_WIDTH-1:0] back_value;
   logic                   any_match;
   logic                   is_zero_cnt;

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;

   assign ctl.mode  = mode;
   assign ctl.key   = key_ff;
   assign ctl.count = count_ff;

   // Build the cell chain
   assign kill_w[0] = 1'b0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_v, right_v;
      if (i == 0) begin : g_head
         assign left_v = key_ff;
      end else begin : g_mid_l
         assign left_v = value_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_v = value_w[i];
      end else begin : g_mid_r
         assign right_v = value_w[i+1];
      end
      bdq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .cell_index  (IDX_W'(i)),
         .left_value  (left_v),
         .right_value (right_v),
         .kill_in     (kill_w[i]),
         .value_out   (value_w[i]),
         .tail_value  (tail_w[i]),
         .kill_out    (kill_w[i+1])
      );
   end

   assign any_match   = kill_w[DEPTH];
   assign is_zero_cnt = count_ff == '0;

   // Gather the back word: only the last occupied cell drives nonzero
   always_comb begin
      back_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_value = back_value | tail_w[i];
      end
   end

   // Apply the command to the chain
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      found_in  = found_ff;
      mode      = CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_OP;
               status_in = STATUS_OK;
               popped_in = '0;
               found_in  = 1'b0;
            end
         end
         ST_OP: begin
            state_in = ST_FIN;
            case (cmd_ff)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (key_ff == '0) begin
                     status_in = STATUS_ZERO;
                  end else if (count_ff == CNT_W'(DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mode     = (cmd_ff == CMD_PUSH_FRONT) ? CELL_TAKE_LEFT : CELL_LOAD;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_POP_FRONT: begin
                  if (is_zero_cnt) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     popped_in = value_w[0];
                     mode      = CELL_TAKE_RIGHT;
                     count_in  = count_ff - CNT_W'(1);
                  end
               end
               CMD_POP_BACK: begin
                  if (is_zero_cnt) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     popped_in = back_value;
                     count_in  = count_ff - CNT_W'(1);
                  end
               end
               CMD_CONTAINS: found_in = any_match;
               CMD_REMOVE: begin
                  // Drop the first match each cycle until none is left
                  if (any_match) begin
                     mode     = CELL_COMPACT;
                     count_in = count_ff - CNT_W'(1);
                     state_in = ST_OP;
                  end
               end
               CMD_CLEAR: count_in = '0;
               default: count_in = count_ff;
            endcase
         end
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= state_ff == ST_FIN;
      end
   end

   // Latch the command word and build the result word
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
      found_ff  <= found_in;
      if (accept) begin
         cmd_ff <= req_command;
         key_ff <= req_item_value;
      end
      if (state_ff == ST_FIN) begin
         front_ff     <= is_zero_cnt ? '0 : value_w[0];
         back_ff      <= back_value;
         empty_ff     <= is_zero_cnt;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_found        = found_ff;
   assign rsp_front_value  = front_ff;
   assign rsp_back_value   = back_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bdq_checker.sv =====
// Port-level checks for the deque, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_with_search_assert.svh"
module bdq_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           rsp_valid,
   input wire logic [bdq_pkg::VALUE_WIDTH-1:0] rsp_front_value,
   input wire logic [bdq_pkg::VALUE_WIDTH-1:0] rsp_back_value,
   input wire logic                           rsp_is_empty,
   input wire logic [bdq_pkg::CNT_W-1:0]      rsp_entry_count
);
   import bdq_pkg::*;

   // An accepted word holds the block busy
   `BDQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A result strobe lasts one cycle
   `BDQ_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   // Empty flag agrees with the count
   `BDQ_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid, rsp_is_empty == (rsp_entry_count == '0))
   // Count never exceeds capacity
   `BDQ_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, rsp_entry_count <= CNT_W'(DEPTH))
   // An empty store shows zero at both ends
   `BDQ_ASSERT_NOW(a_empty_ends, clock, reset, rsp_valid && rsp_is_empty, rsp_front_value == '0 && rsp_back_value == '0)

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (.*);
`default_nettype wire
